// File: rtl/ddc_pkg.sv
// Shared types, codes and constants for the digital down-converter.
// Also holds the elaboration-time quarter-wave sine point generator.
// No dependencies.
package ddc_pkg;

    // Defaults for the top-level parameters
    localparam int TAPS_DEFAULT           = 127;
    localparam int SAMPLE_BITS_DEFAULT    = 16;
    localparam int COEF_BITS_DEFAULT      = 18;
    localparam int PHASE_BITS_DEFAULT     = 32;
    localparam int SINE_ADDR_BITS_DEFAULT = 10;

    // Fixed field widths
    localparam int TAP_INDEX_BITS   = 7;
    localparam int STEP_BITS        = 32;
    localparam int DECIM_BITS       = 13;
    localparam int DECIM_COUNT_BITS = 12;
    localparam int DECIM_MAX        = 4096;
    localparam int CFG_INDEX_BITS   = 1;
    localparam int CFG_DATA_BITS    = 32;

    // Sine/cosine words are Q1.15
    localparam int TRIG_BITS = 16;
    localparam int TRIG_FRAC = 15;

    // pi/2 in Q2.30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_LOAD   = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_BITS-1:0]
    {
        REG_PHASE_STEP = 1'b0,
        REG_DECIMATION = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PRODUCT,
        ST_SHIFT,
        ST_ACCUM,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Control handed to every tap cell of the ring
    typedef struct packed
    {
        logic shift;
        logic rotate;
    } cell_ctrl_t;

    // Quarter-wave sine point k of a table with 2^addr_bits entries per turn.
    // Taylor series in Q2.30 up to x^15, rounded half up to Q1.15.
    function automatic logic [TRIG_BITS-1:0] sine_point(input int unsigned k,
                                                        input int unsigned addr_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      r;
        int          n;
        x    = (HALF_PI_Q30 * 64'(k) + (64'd1 << (addr_bits - 3))) >> (addr_bits - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 7; n++)
        begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (sum + 64'sd16384) >>> TRIG_FRAC;
        if (r > 32767)
            r = 32767;
        return TRIG_BITS'(r);
    endfunction

endpackage

// File: rtl/ddc_in_if.sv
// Input channel of the down-converter: valid/ready plus one sample or tap load.
// Depends on ddc_pkg for default widths.
interface ddc_in_if
    import ddc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
    parameter int COEF_BITS   = COEF_BITS_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;
    logic [TAP_INDEX_BITS-1:0]     tap_index;
    logic signed [COEF_BITS-1:0]   tap_value;

    modport source
    (
        output valid,
        output operation,
        output sample_i,
        output sample_q,
        output tap_index,
        output tap_value,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  operation,
        input  sample_i,
        input  sample_q,
        input  tap_index,
        input  tap_value,
        output ready
    );
endinterface

// File: rtl/ddc_out_if.sv
// Output channel of the down-converter: valid/ready plus one filtered I/Q pair.
// Depends on ddc_pkg for default widths.
interface ddc_out_if
    import ddc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_i;
    logic signed [SAMPLE_BITS-1:0] out_q;

    modport source
    (
        output valid,
        output out_i,
        output out_q,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  out_i,
        input  out_q,
        output ready
    );
endinterface

// File: rtl/digital_down_converter.sv
// Digital down-converter: NCO mixer, complex FIR filter and decimator.
// Depends on ddc_pkg, ddc_in_if, ddc_out_if, ddc_nco and ddc_tap_cell.
//
// Each transfer on the samples channel is either a wideband I/Q sample or a
// coefficient load. A load (tap_index below TAPS) writes one coefficient and
// touches nothing else. A sample is rotated by the NCO phase held before its
// own advance, rounded and saturated to SAMPLE_BITS, then shifted into a ring
// of TAPS tap cells whose history starts at zero. Every decimation-th sample
// triggers one filter output: the ring rotates once around while a single
// complex multiply-accumulate at the head cell sums history times coefficient,
// one tap per cycle, and the rounded, saturated sum lands in the output
// register once the previous result has been taken. The block takes no new
// item until it is through with the current one. The output register holds
// a finished result while new samples are taken. Load every coefficient that
// the filter will use before sending samples. Write configuration only while
// the block is idle; decimation 0 acts as 1 and values above 4096 act as 4096.
module digital_down_converter
    import ddc_pkg::*;
#(
    parameter int TAPS           = TAPS_DEFAULT,
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEFAULT,
    parameter int COEF_BITS      = COEF_BITS_DEFAULT,
    parameter int PHASE_BITS     = PHASE_BITS_DEFAULT,
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    ddc_in_if.sink                    samples,
    ddc_out_if.source                 results
);
    // Mixer widths
    localparam int PROD_W = SAMPLE_BITS + TRIG_BITS;
    localparam int MIX_W  = PROD_W + 1;
    // Filter widths
    localparam int MAC_W  = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = MAC_W + $clog2(TAPS + 1);
    localparam int RND_W  = ACC_W + 1;
    localparam int CNT_W  = (TAPS > 1) ? $clog2(TAPS) : 1;

    localparam logic signed [MIX_W-1:0] MIX_HALF = MIX_W'(1) << (TRIG_FRAC - 1);
    localparam logic signed [MIX_W-1:0] MIX_MAX  = MIX_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [MIX_W-1:0] MIX_MIN  = -MIX_MAX - MIX_W'(1);
    localparam logic signed [RND_W-1:0] ACC_HALF = RND_W'(1) << (COEF_BITS - 2);
    localparam logic signed [RND_W-1:0] ACC_MAX  = RND_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RND_W-1:0] ACC_MIN  = -ACC_MAX - RND_W'(1);

    // Control
    state_t                       state_reg;
    state_t                       state_next;
    cell_ctrl_t                   ctrl;
    logic                         in_transfer;
    logic                         take_sample;
    logic                         take_load;
    logic                         res_free;
    logic                         res_load;

    // Configuration
    logic [STEP_BITS-1:0]         phase_step_reg;
    logic [DECIM_BITS-1:0]        decimation_reg;
    logic [DECIM_BITS-1:0]        dec_eff;

    // Decimation
    logic [DECIM_COUNT_BITS-1:0]  dec_cnt_reg;
    logic [DECIM_COUNT_BITS-1:0]  dec_cnt_next;
    logic [DECIM_BITS-1:0]        dec_cnt_inc;
    logic [DECIM_BITS-1:0]        dec_cnt_wrap;
    logic                         emit_reg;

    // Mixer
    logic signed [TRIG_BITS-1:0]   sin_val;
    logic signed [TRIG_BITS-1:0]   cos_val;
    logic signed [SAMPLE_BITS-1:0] si_reg;
    logic signed [SAMPLE_BITS-1:0] sq_reg;
    logic signed [PROD_W-1:0]      p_ic_reg;
    logic signed [PROD_W-1:0]      p_qs_reg;
    logic signed [PROD_W-1:0]      p_is_reg;
    logic signed [PROD_W-1:0]      p_qc_reg;
    logic signed [MIX_W-1:0]       re_sum;
    logic signed [MIX_W-1:0]       im_sum;
    logic signed [MIX_W-1:0]       re_sh;
    logic signed [MIX_W-1:0]       im_sh;
    logic signed [SAMPLE_BITS-1:0] mix_re;
    logic signed [SAMPLE_BITS-1:0] mix_im;

    // Tap ring
    logic signed [SAMPLE_BITS-1:0] hist_i [TAPS];
    logic signed [SAMPLE_BITS-1:0] hist_q [TAPS];
    logic signed [COEF_BITS-1:0]   coef   [TAPS];
    logic [TAPS-1:0]               load_hit;

    // MAC
    logic [CNT_W-1:0]              cnt_reg;
    logic signed [MAC_W-1:0]       prod_i_reg;
    logic signed [MAC_W-1:0]       prod_q_reg;
    logic signed [ACC_W-1:0]       acc_i_reg;
    logic signed [ACC_W-1:0]       acc_q_reg;
    logic signed [RND_W-1:0]       rnd_i;
    logic signed [RND_W-1:0]       rnd_q;
    logic signed [RND_W-1:0]       rsh_i;
    logic signed [RND_W-1:0]       rsh_q;
    logic signed [SAMPLE_BITS-1:0] fir_i;
    logic signed [SAMPLE_BITS-1:0] fir_q;

    // Output register
    logic                          res_valid_reg;
    logic signed [SAMPLE_BITS-1:0] res_i_reg;
    logic signed [SAMPLE_BITS-1:0] res_q_reg;

    assign in_transfer = samples.valid && samples.ready;
    assign take_sample = in_transfer && (op_t'(samples.operation) == OP_SAMPLE);
    assign take_load   = in_transfer && (op_t'(samples.operation) == OP_LOAD);
    assign res_free    = !res_valid_reg || results.ready;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            decimation_reg <= DECIM_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PHASE_STEP: phase_step_reg <= cfg_data[STEP_BITS-1:0];
                REG_DECIMATION: decimation_reg <= cfg_data[DECIM_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Decimation counter: an output is due when the count is zero before
    // the sample; advance and wrap at the clamped decimation value
    // ---------------------------------------------------------------
    always_comb
    begin
        if (decimation_reg == '0)
            dec_eff = DECIM_BITS'(1);
        else if (decimation_reg > DECIM_BITS'(DECIM_MAX))
            dec_eff = DECIM_BITS'(DECIM_MAX);
        else
            dec_eff = decimation_reg;
        dec_cnt_inc  = {1'b0, dec_cnt_reg} + DECIM_BITS'(1);
        dec_cnt_wrap = {1'b0, dec_cnt_inc[DECIM_COUNT_BITS-1:0]};
        dec_cnt_next = (dec_cnt_wrap >= dec_eff) ? '0 : dec_cnt_inc[DECIM_COUNT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_cnt_reg <= '0;
            emit_reg    <= 1'b0;
        end
        else if (take_sample)
        begin
            dec_cnt_reg <= dec_cnt_next;
            emit_reg    <= (dec_cnt_reg == '0);
        end
    end

    // ---------------------------------------------------------------
    // NCO: sine/cosine of the pre-advance phase, registered on the transfer
    // ---------------------------------------------------------------
    ddc_nco #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_nco (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (take_sample),
        .phase_step (phase_step_reg),
        .sin_val    (sin_val),
        .cos_val    (cos_val)
    );

    // ---------------------------------------------------------------
    // Mixer: hold the sample, form four products, then round and saturate
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            si_reg <= samples.sample_i;
            sq_reg <= samples.sample_q;
        end
        if (state_reg == ST_PRODUCT)
        begin
            p_ic_reg <= si_reg * cos_val;
            p_qs_reg <= sq_reg * sin_val;
            p_is_reg <= si_reg * sin_val;
            p_qc_reg <= sq_reg * cos_val;
        end
    end

    always_comb
    begin
        re_sum = MIX_W'(p_ic_reg) - MIX_W'(p_qs_reg) + MIX_HALF;
        im_sum = MIX_W'(p_is_reg) + MIX_W'(p_qc_reg) + MIX_HALF;
        re_sh  = re_sum >>> TRIG_FRAC;
        im_sh  = im_sum >>> TRIG_FRAC;
        if (re_sh > MIX_MAX)
            mix_re = MIX_MAX[SAMPLE_BITS-1:0];
        else if (re_sh < MIX_MIN)
            mix_re = MIX_MIN[SAMPLE_BITS-1:0];
        else
            mix_re = re_sh[SAMPLE_BITS-1:0];
        if (im_sh > MIX_MAX)
            mix_im = MIX_MAX[SAMPLE_BITS-1:0];
        else if (im_sh < MIX_MIN)
            mix_im = MIX_MIN[SAMPLE_BITS-1:0];
        else
            mix_im = im_sh[SAMPLE_BITS-1:0];
    end

    // ---------------------------------------------------------------
    // Tap ring: cell 0 is the newest sample and the MAC head. A shift moves
    // history one cell down; a rotate moves history and coefficients one
    // cell up, so TAPS rotates bring the ring back home.
    // ---------------------------------------------------------------
    for (genvar k = 0; k < TAPS; k++)
    begin : g_ring
        localparam int NEXT = (k + 1) % TAPS;

        logic signed [SAMPLE_BITS-1:0] up_i;
        logic signed [SAMPLE_BITS-1:0] up_q;

        assign load_hit[k] = take_load &&
                             ({{(32 - TAP_INDEX_BITS){1'b0}}, samples.tap_index} == 32'(k));

        if (k == 0)
        begin : g_head
            assign up_i = mix_re;
            assign up_q = mix_im;
        end
        else
        begin : g_body
            assign up_i = hist_i[k-1];
            assign up_q = hist_q[k-1];
        end

        ddc_tap_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .COEF_BITS   (COEF_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .coef_load  (load_hit[k]),
            .load_value (samples.tap_value),
            .shift_i    (up_i),
            .shift_q    (up_q),
            .rot_i      (hist_i[NEXT]),
            .rot_q      (hist_q[NEXT]),
            .rot_coef   (coef[NEXT]),
            .hist_i     (hist_i[k]),
            .hist_q     (hist_q[k]),
            .coef       (coef[k])
        );
    end

    // ---------------------------------------------------------------
    // MAC at the head cell: product registered first, then summed from that register later
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (state_reg == ST_ACCUM)
            cnt_reg <= cnt_reg + CNT_W'(1);
        else
            cnt_reg <= '0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ACCUM)
        begin
            prod_i_reg <= hist_i[0] * coef[0];
            prod_q_reg <= hist_q[0] * coef[0];
            if (cnt_reg == '0)
            begin
                acc_i_reg <= '0;
                acc_q_reg <= '0;
            end
            else
            begin
                acc_i_reg <= acc_i_reg + ACC_W'(prod_i_reg);
                acc_q_reg <= acc_q_reg + ACC_W'(prod_q_reg);
            end
        end
        else if (state_reg == ST_DRAIN)
        begin
            acc_i_reg <= acc_i_reg + ACC_W'(prod_i_reg);
            acc_q_reg <= acc_q_reg + ACC_W'(prod_q_reg);
        end
    end

    // Round half up at COEF_BITS-1 fraction bits, saturate to the sample range
    always_comb
    begin
        rnd_i = RND_W'(acc_i_reg) + ACC_HALF;
        rnd_q = RND_W'(acc_q_reg) + ACC_HALF;
        rsh_i = rnd_i >>> (COEF_BITS - 1);
        rsh_q = rnd_q >>> (COEF_BITS - 1);
        if (rsh_i > ACC_MAX)
            fir_i = ACC_MAX[SAMPLE_BITS-1:0];
        else if (rsh_i < ACC_MIN)
            fir_i = ACC_MIN[SAMPLE_BITS-1:0];
        else
            fir_i = rsh_i[SAMPLE_BITS-1:0];
        if (rsh_q > ACC_MAX)
            fir_q = ACC_MAX[SAMPLE_BITS-1:0];
        else if (rsh_q < ACC_MIN)
            fir_q = ACC_MIN[SAMPLE_BITS-1:0];
        else
            fir_q = rsh_q[SAMPLE_BITS-1:0];
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_sample)
                    state_next = ST_PRODUCT;
            end
            ST_PRODUCT:
            begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                state_next = emit_reg ? ST_ACCUM : ST_IDLE;
            end
            ST_ACCUM:
            begin
                if (cnt_reg == CNT_W'(TAPS - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (res_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        samples.ready = (state_reg == ST_IDLE);
        ctrl.shift    = (state_reg == ST_SHIFT);
        ctrl.rotate   = (state_reg == ST_ACCUM);
        res_load      = (state_reg == ST_EMIT) && res_free;
    end

    // ---------------------------------------------------------------
    // Output register: hold a result until its transfer completes
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_load)
            res_valid_reg <= 1'b1;
        else if (results.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_i_reg <= fir_i;
            res_q_reg <= fir_q;
        end
    end

    assign results.valid = res_valid_reg;
    assign results.out_i = res_i_reg;
    assign results.out_q = res_q_reg;

`ifndef SYNTHESIS
    // The MAC walk ends only after every tap has passed the head cell
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCUM && state_next != ST_ACCUM) |-> cnt_reg == CNT_W'(TAPS - 1))
        else $error("MAC walk left early at count %0d", cnt_reg);

    // A coefficient load leaves the decimation phase alone
    assert property (@(posedge clk) disable iff (!rst_n)
        take_load |=> $stable(dec_cnt_reg))
        else $error("coefficient load moved the decimation counter");

    // A new result appears only out of the emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside the emit step");
`endif
endmodule

// File: rtl/ddc_nco.sv
// Numerically controlled oscillator: phase accumulator and quarter-wave sine table.
// Registers sine and cosine of the phase held before each advance. Depends on ddc_pkg.
module ddc_nco
    import ddc_pkg::*;
#(
    parameter int PHASE_BITS     = PHASE_BITS_DEFAULT,
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [STEP_BITS-1:0]        phase_step,
    output logic signed [TRIG_BITS-1:0] sin_val,
    output logic signed [TRIG_BITS-1:0] cos_val
);
    localparam int QUARTER = 2 ** (SINE_ADDR_BITS - 2);
    localparam int QR_W    = SINE_ADDR_BITS - 2;
    localparam int QI_W    = SINE_ADDR_BITS - 1;

    logic [TRIG_BITS-2:0]        qsine [QUARTER+1];
    logic [PHASE_BITS-1:0]       phase_reg;
    logic [PHASE_BITS-1:0]       phase_next;
    logic [PHASE_BITS-1:0]       step;
    logic [SINE_ADDR_BITS-1:0]   addr_s;
    logic [SINE_ADDR_BITS-1:0]   addr_c;
    logic [QI_W-1:0]             idx_s;
    logic [QI_W-1:0]             idx_c;
    logic signed [TRIG_BITS-1:0] mag_s;
    logic signed [TRIG_BITS-1:0] mag_c;
    logic signed [TRIG_BITS-1:0] sin_next;
    logic signed [TRIG_BITS-1:0] cos_next;
    logic signed [TRIG_BITS-1:0] sin_reg;
    logic signed [TRIG_BITS-1:0] cos_reg;

    for (genvar k = 0; k <= QUARTER; k++)
    begin : g_qsine
        localparam logic [TRIG_BITS-1:0] POINT = sine_point(k, SINE_ADDR_BITS);
        assign qsine[k] = POINT[TRIG_BITS-2:0];
    end

    // Sign-extend the step past 32 bits, else keep its low bits
    if (PHASE_BITS <= STEP_BITS)
    begin : g_step_trunc
        assign step = phase_step[PHASE_BITS-1:0];
    end
    else
    begin : g_step_ext
        assign step = {{(PHASE_BITS - STEP_BITS){phase_step[STEP_BITS-1]}}, phase_step};
    end

    assign addr_s     = phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign addr_c     = addr_s + SINE_ADDR_BITS'(QUARTER);
    assign phase_next = phase_reg + step;

    // Fold odd quadrants back onto the quarter table, negate the lower half
    always_comb
    begin
        idx_s = addr_s[SINE_ADDR_BITS-2] ? QI_W'(QUARTER) - {1'b0, addr_s[QR_W-1:0]}
                                         : {1'b0, addr_s[QR_W-1:0]};
        idx_c = addr_c[SINE_ADDR_BITS-2] ? QI_W'(QUARTER) - {1'b0, addr_c[QR_W-1:0]}
                                         : {1'b0, addr_c[QR_W-1:0]};
        mag_s = {1'b0, qsine[idx_s]};
        mag_c = {1'b0, qsine[idx_c]};
        sin_next = addr_s[SINE_ADDR_BITS-1] ? -mag_s : mag_s;
        cos_next = addr_c[SINE_ADDR_BITS-1] ? -mag_c : mag_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (advance)
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;
endmodule

// File: rtl/ddc_tap_cell.sv
// One cell of the filter ring: a complex history word and its coefficient.
// Shifts history from the upstream cell, or rotates both words from the downstream cell.
// Depends on ddc_pkg.
module ddc_tap_cell
    import ddc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
    parameter int COEF_BITS   = COEF_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_ctrl_t                    ctrl,
    input  logic                          coef_load,
    input  logic signed [COEF_BITS-1:0]   load_value,
    input  logic signed [SAMPLE_BITS-1:0] shift_i,
    input  logic signed [SAMPLE_BITS-1:0] shift_q,
    input  logic signed [SAMPLE_BITS-1:0] rot_i,
    input  logic signed [SAMPLE_BITS-1:0] rot_q,
    input  logic signed [COEF_BITS-1:0]   rot_coef,
    output logic signed [SAMPLE_BITS-1:0] hist_i,
    output logic signed [SAMPLE_BITS-1:0] hist_q,
    output logic signed [COEF_BITS-1:0]   coef
);
    logic signed [SAMPLE_BITS-1:0] hist_i_reg;
    logic signed [SAMPLE_BITS-1:0] hist_q_reg;
    logic signed [COEF_BITS-1:0]   coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_i_reg <= '0;
            hist_q_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            hist_i_reg <= shift_i;
            hist_q_reg <= shift_q;
        end
        else if (ctrl.rotate)
        begin
            hist_i_reg <= rot_i;
            hist_q_reg <= rot_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_load)
            coef_reg <= load_value;
        else if (ctrl.rotate)
            coef_reg <= rot_coef;
    end

    assign hist_i = hist_i_reg;
    assign hist_q = hist_q_reg;
    assign coef   = coef_reg;
endmodule

// File: verif/ddc_checker.sv
// Scoreboard for the digital down-converter: mirrors the NCO mixer, delay line and decimator.
// Depends on ddc_pkg and on the ddc_in_if / ddc_out_if channel interfaces.
module ddc_checker
    import ddc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    ddc_in_if                         samples,
    ddc_out_if                        results,
    output int                        failures,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTAPS = TAPS_DEFAULT;
    localparam int SW    = SAMPLE_BITS_DEFAULT;
    localparam int CW    = COEF_BITS_DEFAULT;
    localparam int PW    = PHASE_BITS_DEFAULT;
    localparam int AW    = SINE_ADDR_BITS_DEFAULT;
    localparam int QTR   = 1 << (AW - 2);

    localparam longint SAMPLE_MAX = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    typedef struct
    {
        logic signed [SW-1:0] i;
        logic signed [SW-1:0] q;
    } iq_t;

    int                   quarter_tbl [0:QTR];
    logic [PW-1:0]        phase_acc;
    logic [STEP_BITS-1:0] phase_incr;
    logic [DECIM_BITS-1:0] decim_setting;
    int                   decim_phase;
    logic signed [SW-1:0] delay_i [NTAPS];
    logic signed [SW-1:0] delay_q [NTAPS];
    logic signed [CW-1:0] taps [NTAPS];
    iq_t                  expected_out [$];
    int                   mismatches = 0;
    iq_t                  want;
    iq_t                  fresh;
    bit                   emits;

    // One point of the quarter wave: Taylor series in Q2.30, rounded to Q1.15
    function automatic int quarter_point(input int k);
        longint unsigned angle;
        longint unsigned angle_sq;
        longint unsigned power;
        longint          series;
        longint          rounded;
        int              n;
        angle    = (HALF_PI_Q30 * 64'(k) + 64'(QTR / 2)) / 64'(QTR);
        angle_sq = (angle * angle) >> 30;
        power    = angle;
        series   = longint'(angle);
        for (n = 1; n <= 7; n++)
        begin
            power = (power * angle_sq) >> 30;
            power = power / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                series = series - longint'(power);
            else
                series = series + longint'(power);
        end
        if (series < 0)
            series = 0;
        rounded = (series + 16384) >>> 15;
        if (rounded > 32767)
            rounded = 32767;
        return int'(rounded);
    endfunction

    function automatic int sine_lookup(input logic [AW-1:0] addr);
        logic [1:0]    quad;
        logic [AW-3:0] offs;
        int            mag;
        quad = addr[AW-1 -: 2];
        offs = addr[AW-3:0];
        mag  = quad[0] ? quarter_tbl[QTR - int'(offs)] : quarter_tbl[offs];
        return quad[1] ? -mag : mag;
    endfunction

    function automatic logic signed [SW-1:0] clip_sample(input longint v);
        if (v > SAMPLE_MAX)
            return SW'(SAMPLE_MAX);
        if (v < SAMPLE_MIN)
            return SW'(SAMPLE_MIN);
        return SW'(v);
    endfunction

    function automatic void clear_model();
        int k;
        phase_acc     = '0;
        phase_incr    = '0;
        decim_setting = DECIM_BITS'(1);
        decim_phase   = 0;
        for (k = 0; k < NTAPS; k++)
        begin
            delay_i[k] = '0;
            delay_q[k] = '0;
            taps[k]    = '0;
        end
        expected_out.delete();
    endfunction

    // Mix one sample, push it into the delay line and run the decimator
    function automatic void absorb_sample(input logic signed [SW-1:0] si,
                                          input logic signed [SW-1:0] sq,
                                          output bit emit, output iq_t res);
        logic [AW-1:0] sin_addr;
        logic [AW-1:0] cos_addr;
        longint        s;
        longint        c;
        longint        acc_i;
        longint        acc_q;
        int            dec;
        int            k;
        sin_addr  = phase_acc[PW-1 -: AW];
        cos_addr  = sin_addr + AW'(QTR);
        s         = sine_lookup(sin_addr);
        c         = sine_lookup(cos_addr);
        phase_acc = phase_acc + phase_incr;

        for (k = NTAPS - 1; k > 0; k--)
        begin
            delay_i[k] = delay_i[k-1];
            delay_q[k] = delay_q[k-1];
        end
        delay_i[0] = clip_sample((longint'(si) * c - longint'(sq) * s + 16384) >>> 15);
        delay_q[0] = clip_sample((longint'(si) * s + longint'(sq) * c + 16384) >>> 15);

        if (decim_setting == 0)
            dec = 1;
        else if (decim_setting > DECIM_MAX)
            dec = DECIM_MAX;
        else
            dec = int'(decim_setting);

        emit  = (decim_phase == 0);
        res.i = '0;
        res.q = '0;
        if (emit)
        begin
            acc_i = 0;
            acc_q = 0;
            for (k = 0; k < NTAPS; k++)
            begin
                acc_i += longint'(delay_i[k]) * longint'(taps[k]);
                acc_q += longint'(delay_q[k]) * longint'(taps[k]);
            end
            res.i = clip_sample((acc_i + (longint'(1) <<< (CW - 2))) >>> (CW - 1));
            res.q = clip_sample((acc_q + (longint'(1) <<< (CW - 2))) >>> (CW - 1));
            decim_phase = 1;
        end
        else
            decim_phase = (decim_phase + 1) & ((1 << DECIM_COUNT_BITS) - 1);
        if (decim_phase >= dec)
            decim_phase = 0;
    endfunction

    initial
    begin
        for (int k = 0; k <= QTR; k++)
            quarter_tbl[k] = quarter_point(k);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_PHASE_STEP)
                    phase_incr = cfg_data[STEP_BITS-1:0];
                else if (cfg_index == REG_DECIMATION)
                    decim_setting = cfg_data[DECIM_BITS-1:0];
            end

            if (samples.valid && samples.ready)
            begin
                if (samples.operation == OP_LOAD)
                begin
                    // drop loads aimed past the last tap
                    if (samples.tap_index < NTAPS)
                        taps[samples.tap_index] = samples.tap_value;
                end
                else
                begin
                    absorb_sample(samples.sample_i, samples.sample_q, emits, fresh);
                    if (emits)
                        expected_out.insert(expected_out.size(), fresh);
                end
            end

            if (results.valid && results.ready)
            begin
                if (expected_out.size() == 0)
                begin
                    $error("out_i/out_q: unexpected result %0d/%0d",
                           results.out_i, results.out_q);
                    mismatches++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (results.out_i !== want.i)
                    begin
                        $error("out_i: expected %0d, actual %0d", want.i, results.out_i);
                        mismatches++;
                    end
                    if (results.out_q !== want.q)
                    begin
                        $error("out_q: expected %0d, actual %0d", want.q, results.out_q);
                        mismatches++;
                    end
                end
            end

            pending <= expected_out.size();
        end
    end

    assign failures = mismatches;

endmodule

// File: verif/testbench.sv
// Top of the down-converter testbench: clock, reset, stimulus, output stalls and verdict.
// Depends on ddc_pkg, ddc_in_if, ddc_out_if, digital_down_converter and ddc_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ddc_pkg::*;

    localparam int NTAPS = TAPS_DEFAULT;

    // A sample that triggers an output keeps the block busy while the MAC walks
    // the ring; give it some slack before touching the configuration.
    localparam int SETTLE_CYCLES = NTAPS + 10;
    localparam int CYCLE_LIMIT   = 1_000_000;

    // Long stall on the output side: hold ready low for this many cycles once
    // this many results have been taken, so the block backs up into its input.
    localparam int LONG_HOLD = 600;
    localparam int HOLD_AT   = 40;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_PHASE_STEP;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    int                        failures;
    int                        pending;
    int                        cycle_count = 0;

    ddc_in_if  samples_ch();
    ddc_out_if results_ch();

    digital_down_converter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_ch),
        .results   (results_ch)
    );

    ddc_checker scoreboard
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_ch),
        .results   (results_ch),
        .failures  (failures),
        .pending   (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: end the run if the block hangs somewhere.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Random field values
    // ------------------------------------------------------------------

    // Favor the rails so the mixer and filter saturate now and then.
    function automatic logic signed [15:0] draw_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly small taps keep the filter out of saturation so rounding is
    // exercised; a few full-range and extreme ones push it into the rails.
    function automatic logic signed [17:0] draw_coef();
        case ($urandom_range(0, 9))
            0:       return 18'($urandom);
            1:       return $urandom_range(0, 1) ? 18'sh1FFFF : 18'sh20000;
            default: return 18'(int'($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    // Every tenth load or so aims at the unused index and must be dropped.
    function automatic logic [6:0] draw_tap_index();
        if ($urandom_range(0, 9) == 0)
            return 7'd127;
        return 7'($urandom_range(0, NTAPS - 1));
    endfunction

    // ------------------------------------------------------------------
    // Channel and register drivers
    // ------------------------------------------------------------------

    // Offer one item after an idle gap; return at the edge of its transfer.
    task automatic offer(input op_t op, input logic signed [15:0] i_val,
                         input logic signed [15:0] q_val, input logic [6:0] idx,
                         input logic signed [17:0] coef, input int gap);
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_ch.operation <= op;
        samples_ch.sample_i  <= i_val;
        samples_ch.sample_q  <= q_val;
        samples_ch.tap_index <= idx;
        samples_ch.tap_value <= coef;
        samples_ch.valid     <= 1'b1;
        do
            @(posedge clk);
        while (!samples_ch.ready);
    endtask

    // Write both registers on back-to-back edges; the block is idle here.
    task automatic configure(input logic [31:0] step, input logic [31:0] dec);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PHASE_STEP;
        cfg_data  <= step;
        @(posedge clk);
        cfg_index <= REG_DECIMATION;
        cfg_data  <= dec;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Stop offering, wait for every predicted output, then wait SETTLE_CYCLES more
    // so that a last sample that yields no output can finish.
    task automatic settle();
        samples_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One configuration setting followed by a stream of random items.
    // Idle gaps come in stretches; some stretches run back to back.
    task automatic run_phase(input logic [31:0] step, input logic [31:0] dec,
                             input int n_items, input int load_pct, input bit idle_on);
        int  n;
        int  gap;
        bit  burst;
        settle();
        configure(step, dec);
        burst = 1'b0;
        for (n = 0; n < n_items; n++)
        begin
            if (n % 20 == 0)
                burst = ($urandom_range(0, 2) == 0);
            gap = (idle_on && !burst) ? $urandom_range(0, 6) : 0;
            if ($urandom_range(0, 99) < load_pct)
                offer(OP_LOAD, draw_sample(), draw_sample(), draw_tap_index(), draw_coef(),
                      gap);
            else
                offer(OP_SAMPLE, draw_sample(), draw_sample(), 7'($urandom), draw_coef(),
                      gap);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls plus one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int taken;
        int gap;
        bit burst;
        taken = 0;
        burst = 1'b0;
        results_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 16 == 0)
                burst = ($urandom_range(0, 2) == 0);
            gap = burst ? 0 : $urandom_range(0, 6);
            if (taken == HOLD_AT)
                gap = LONG_HOLD;
            if (gap > 0)
            begin
                results_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            results_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!results_ch.valid);
            taken++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------
    initial
    begin
        samples_ch.valid     <= 1'b0;
        samples_ch.operation <= OP_SAMPLE;
        samples_ch.sample_i  <= '0;
        samples_ch.sample_q  <= '0;
        samples_ch.tap_index <= '0;
        samples_ch.tap_value <= '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Advance the NCO by an eighth of a turn per sample so the directed
        // samples land on both axes and on the diagonals.
        configure(32'h2000_0000, 32'd1);

        // Load every tap before the first sample reaches the filter.
        for (int k = 0; k < NTAPS; k++)
            offer(OP_LOAD, '0, '0, 7'(k), 18'(int'($urandom_range(0, 8191)) - 4096), 0);

        // Directed part. The load past the last tap must be dropped; taps 0
        // and 1 near +1.0 drive the filter into both rails on full-scale input.
        offer(OP_LOAD,   16'sh0000, 16'sh0000, 7'd127, 18'sh1FFFF, 0);
        offer(OP_LOAD,   16'sh0000, 16'sh0000, 7'd0,   18'sh1FFFF, 1);
        offer(OP_LOAD,   16'sh0000, 16'sh0000, 7'd1,   18'sh1FFFF, 0);
        offer(OP_LOAD,   16'sh0000, 16'sh0000, 7'd126, 18'sh20000, 2);
        offer(OP_SAMPLE, 16'sh7FFF, 16'sh7FFF, 7'd0,   18'sh00000, 0);
        offer(OP_SAMPLE, 16'sh7FFF, 16'sh8000, 7'd0,   18'sh00000, 0);
        offer(OP_SAMPLE, 16'sh8000, 16'sh8000, 7'd0,   18'sh00000, 3);
        offer(OP_SAMPLE, 16'sh8000, 16'sh7FFF, 7'd0,   18'sh00000, 0);
        offer(OP_SAMPLE, 16'sh0000, 16'sh0000, 7'd0,   18'sh00000, 1);
        offer(OP_SAMPLE, 16'sh0001, 16'shFFFF, 7'd0,   18'sh00000, 0);
        offer(OP_SAMPLE, 16'sh7FFF, 16'sh8000, 7'd0,   18'sh00000, 6);
        offer(OP_SAMPLE, 16'sh8000, 16'sh8000, 7'd0,   18'sh00000, 0);
        offer(OP_SAMPLE, 16'sh7FFF, 16'sh7FFF, 7'd0,   18'sh00000, 2);
        offer(OP_SAMPLE, 16'sh8000, 16'sh7FFF, 7'd0,   18'sh00000, 0);
        // Pull the big taps back down so later phases mostly stay in range.
        offer(OP_LOAD,   16'sh0000, 16'sh0000, 7'd0,   18'sh00400, 0);
        offer(OP_LOAD,   16'sh0000, 16'sh0000, 7'd1,   18'sh3FC00, 0);
        offer(OP_LOAD,   16'sh0000, 16'sh0000, 7'd126, 18'sh00200, 0);

        // Random part. The long output stall falls in the first phase, where
        // every sample yields an output and the block backs up fastest.
        run_phase($urandom,      32'd1,    60,   12, 1'b1);
        run_phase(32'h8000_0000, 32'd3,    40,   12, 1'b1);
        // Largest decimation, then an oversized value that must act as the
        // largest; pure samples, back to back. These short phases see at most
        // one output each.
        run_phase(32'hFFFF_FFFF, 32'd4096, 40,   0,  1'b0);
        run_phase(32'h0000_0000, 32'd8191, 40,   0,  1'b0);
        // Lower the decimation while the count is likely above the new value.
        run_phase($urandom,      32'd5,    40,   12, 1'b1);
        // Zero decimation must behave as one.
        run_phase($urandom,      32'd0,    30,   12, 1'b1);
        run_phase($urandom,      32'd2,    50,   15, 1'b1);

        settle();
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
